// ===== hw/rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg
// Types and codes shared by the bounded array list: request and response
// payloads, operation and status codes, memory access bundle, sequencer states.
// ----------------------------------------------------------------------------
package bal_pkg;

   // widest entry address the list may need (up to 256 entries)
   localparam int ADDR_W  = 8;
   localparam int VALUE_W = 32;

   // insert place codes
   localparam logic [1:0] WHERE_POSITION = 2'd0;
   localparam logic [1:0] WHERE_START    = 2'd1;
   localparam logic [1:0] WHERE_END      = 2'd2;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_DUMP   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
      logic [1:0]                 insert_where;
      logic [7:0]                 position;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  item_value;
      logic [3:0]                 item_position;
      logic [4:0]                 count;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [VALUE_W-1:0]  wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_CMP,
      S_SH_RD,
      S_SH_WR,
      S_DUMP_RD,
      S_DUMP_CAP,
      S_EMIT
   } state_type;

endpackage

// ===== hw/rtl/bal_mem.sv =====
// ----------------------------------------------------------------------------
// bal_mem
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bal_mem
   import bal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  mem_req_type         mem_req,
   output logic [VALUE_W-1:0]  mem_rd_data
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] mem_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // write, and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign mem_rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bal_seq.sv =====
// ----------------------------------------------------------------------------
// bal_seq
// Operation sequencer: decodes a request, walks the entry store one entry at
// a time to shift, search or dump, and presents each response.
// ----------------------------------------------------------------------------
module bal_seq
   import bal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_payload,
   output mem_req_type         mem_req,
   input  logic [VALUE_W-1:0]  mem_rd_data,
   output logic                res_valid,
   input  logic                res_ready,
   output rsp_type             res_payload
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [IDX_W-1:0]           hit_ff, hit_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   rsp_type                    res_ff, res_in;

   logic [CNT_W-1:0]           cur_inc;
   logic [CNT_W-1:0]           count_inc;
   logic [CNT_W-1:0]           count_dec;
   logic [CMP_W-1:0]           at_ext;
   logic                       at_ok;

   // build a response, truncating index and count to the port widths
   function automatic rsp_type pack_rsp(status_type st, logic [VALUE_W-1:0] v,
                                        logic [31:0] p, logic [31:0] c, logic l);
      rsp_type r;
      r.status        = st;
      r.item_value    = v;
      r.item_position = p[3:0];
      r.count         = c[4:0];
      r.last          = l;
      return r;
   endfunction

   assign cur_inc   = CNT_W'(cur_ff) + CNT_W'(1);
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);

   // resolve the insert place and check it against the fill
   always_comb begin
      at_ext = '0;
      at_ok  = 1'b0;
      unique case (req_payload.insert_where)
         WHERE_START: begin
            at_ext = '0;
            at_ok  = 1'b1;
         end
         WHERE_END: begin
            at_ext = CMP_W'(count_ff);
            at_ok  = 1'b1;
         end
         WHERE_POSITION: begin
            at_ext = CMP_W'(req_payload.position);
            at_ok  = (at_ext <= CMP_W'(count_ff));
         end
         default: begin
            at_ok  = 1'b0;
         end
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cur_ff <= cur_in;
      hit_ff <= hit_in;
      val_ff <= val_in;
      res_ff <= res_in;
   end

   // next state, memory accesses and response
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      hit_in   = hit_ff;
      val_in   = val_ff;
      res_in   = res_ff;
      mem_req  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_payload.value;
               cur_in = '0;
               unique case (req_payload.kind)
                  KIND_INSERT: begin
                     if (count_ff >= CAP_CNT) begin
                        res_in   = pack_rsp(ST_FULL, '0, '0, 32'(count_ff), 1'b1);
                        state_in = S_EMIT;
                     end else if (at_ok) begin
                        hit_in   = at_ext[IDX_W-1:0];
                        cur_in   = count_ff[IDX_W-1:0];
                        state_in = S_INS_RD;
                     end else begin
                        res_in   = pack_rsp(ST_BADPOS, '0, '0, 32'(count_ff), 1'b1);
                        state_in = S_EMIT;
                     end
                  end
                  KIND_DELETE: begin
                     if (count_ff == '0) begin
                        res_in   = pack_rsp(ST_EMPTY, '0, '0, 32'(count_ff), 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     res_in   = pack_rsp(ST_OK, '0, '0, '0, 1'b1);
                     state_in = S_EMIT;
                  end
                  KIND_DUMP: begin
                     if (count_ff == '0) begin
                        res_in   = pack_rsp(ST_EMPTY, '0, '0, 32'(count_ff), 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // shift up from the top; once the gap reaches its place, drop the value in
         S_INS_RD: begin
            if (cur_ff == hit_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ADDR_W'(cur_ff);
               mem_req.wr_data = val_ff;
               count_in        = count_inc;
               res_in          = pack_rsp(ST_OK, val_ff, 32'(hit_ff), 32'(count_inc), 1'b1);
               state_in        = S_EMIT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_W'(cur_ff - IDX_W'(1));
               state_in        = S_INS_WR;
            end
         end

         S_INS_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_W'(cur_ff);
            mem_req.wr_data = mem_rd_data;
            cur_in          = cur_ff - IDX_W'(1);
            state_in        = S_INS_RD;
         end

         // search for the first match
         S_DEL_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_W'(cur_ff);
            state_in        = S_DEL_CMP;
         end

         S_DEL_CMP: begin
            if (mem_rd_data == val_ff) begin
               hit_in   = cur_ff;
               state_in = S_SH_RD;
            end else if (cur_inc == count_ff) begin
               res_in   = pack_rsp(ST_NOTFOUND, '0, '0, 32'(count_ff), 1'b1);
               state_in = S_EMIT;
            end else begin
               cur_in   = cur_ff + IDX_W'(1);
               state_in = S_DEL_RD;
            end
         end

         // close the gap by moving later entries down
         S_SH_RD: begin
            if (cur_inc < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_W'(cur_inc);
               state_in        = S_SH_WR;
            end else begin
               count_in = count_dec;
               res_in   = pack_rsp(ST_OK, val_ff, 32'(hit_ff), 32'(count_dec), 1'b1);
               state_in = S_EMIT;
            end
         end

         S_SH_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_W'(cur_ff);
            mem_req.wr_data = mem_rd_data;
            cur_in          = cur_ff + IDX_W'(1);
            state_in        = S_SH_RD;
         end

         // dump one entry per pass
         S_DUMP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_W'(cur_ff);
            state_in        = S_DUMP_CAP;
         end

         S_DUMP_CAP: begin
            res_in   = pack_rsp(ST_OK, mem_rd_data, 32'(cur_ff), 32'(count_ff),
                                cur_inc == count_ff);
            state_in = S_EMIT;
         end

         // hold the response until taken, then finish or fetch the next entry
         S_EMIT: begin
            if (res_ready) begin
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = cur_ff + IDX_W'(1);
                  state_in = S_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign res_valid   = (state_ff == S_EMIT);
   assign res_payload = res_ff;

   // fill never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // the store is never read and written in the same cycle
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("read and write in one cycle");

   // a pending response holds until it is taken
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !res_ready) |=> (state_ff == S_EMIT && $stable(res_ff)))
      else $error("response dropped before hand-off");

   // the fill only moves on the way to a response
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      (count_ff != count_in) |=> (state_ff == S_EMIT))
      else $error("entry count changed outside an operation end");

endmodule

// ===== hw/rtl/bounded_array_list.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete by
// value, clear and dump, held in a single-port-read synchronous store.
// ----------------------------------------------------------------------------
// Sequencing: clear and errors go straight from idle to the response; insert
//   shifts each entry above its place up with a read and a write; delete
//   reads and compares until the match, then moves later entries down. One
//   request at a time; a dump reads, captures and hands off each entry.
// Reset: the fill count and all control state clear; entries stay undefined
//   and are never read before written, so no clearing pass runs.
module bounded_array_list
   import bal_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   mem_req_type         mem_req;
   logic [VALUE_W-1:0]  mem_rd_data;
   logic                res_valid;
   logic                res_ready;
   rsp_type             res_payload;

   logic                rsp_valid_ff;
   rsp_type             rsp_payload_ff;

   bal_mem #(
      .CAPACITY (CAPACITY)
   ) u_mem (
      .clock       (clock),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   bal_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== test/tb_bounded_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list
// Self-checking bench for the bounded array list. A scripted run covers the
// empty, full and bad-position cases and the value extremes, then random
// inserts, deletes, clears and dumps follow. Every response is compared with
// a shadow list kept in the bench or a typed expectation. The sender runs in
// bursts; the receiver stalls in shifting patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;
   import bal_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_REQS  = 250;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 70;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [1:0] WHERE_UNDEFINED = 2'd3;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef enum int {RX_FREE, RX_COIN, RX_BUSY, RX_EVERY_THIRD} rx_mode_type;

   typedef struct {
      req_type req;
      int      reps;
      bit      typed;
      rsp_type exp;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // expectation typed into the script, travelling with the request
   bit      offer_typed = 1'b0;
   rsp_type offer_exp = '0;

   // shadow of the list
   logic signed [31:0] list_vals [LIST_DEPTH];
   int                 list_len = 0;
   rsp_type            step_rsps [$];
   rsp_type            pending_rsps [$];

   // bookkeeping
   int accepted_reqs = 0;
   int scripted_reqs = 0;
   int checked_rsps = 0;
   int mismatches = 0;
   int status_seen [5] = '{default: 0};
   int burst_left = 0;
   logic signed [31:0] recent_vals [$];

   bounded_array_list #(.CAPACITY(LIST_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // give up on a hung run
   initial begin
      #5_000_000;
      $display("watchdog expired with %0d responses outstanding", pending_rsps.size());
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // shadow list
   // ------------------------------------------------------------------
   task automatic push_rsp(status_type s, logic signed [31:0] v, int p, bit l);
      rsp_type o;
      o.status        = s;
      o.item_value    = v;
      o.item_position = p[3:0];
      o.count         = list_len[4:0];
      o.last          = l;
      step_rsps.push_back(o);
   endtask

   task automatic list_apply(input req_type r);
      int at;
      int hit;
      int i;
      step_rsps.delete();
      case (r.kind)
         KIND_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               push_rsp(ST_FULL, 0, 0, 1'b1);
            end else begin
               case (r.insert_where)
                  WHERE_START:    at = 0;
                  WHERE_END:      at = list_len;
                  WHERE_POSITION: at = int'(r.position);
                  default:        at = list_len + 1;
               endcase
               if (at > list_len) begin
                  push_rsp(ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  // open a gap at the target index
                  for (i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
                  list_vals[at] = r.value;
                  list_len++;
                  push_rsp(ST_OK, r.value, at, 1'b1);
               end
            end
         end
         KIND_DELETE: begin
            if (list_len == 0) begin
               push_rsp(ST_EMPTY, 0, 0, 1'b1);
            end else begin
               hit = -1;
               for (i = 0; i < list_len; i++)
                  if (hit < 0 && list_vals[i] == r.value) hit = i;
               if (hit < 0) begin
                  push_rsp(ST_NOTFOUND, 0, 0, 1'b1);
               end else begin
                  // close the gap behind the first match
                  for (i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
                  list_len--;
                  push_rsp(ST_OK, r.value, hit, 1'b1);
               end
            end
         end
         KIND_CLEAR: begin
            list_len = 0;
            push_rsp(ST_OK, 0, 0, 1'b1);
         end
         default: begin
            if (list_len == 0) push_rsp(ST_EMPTY, 0, 0, 1'b1);
            else
               for (i = 0; i < list_len; i++)
                  push_rsp(ST_OK, list_vals[i], i, i == list_len - 1);
         end
      endcase
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      checked_rsps++;
      if (pending_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected response: status=%0d value=%0d pos=%0d count=%0d last=%0d",
                     got.status, got.item_value, got.item_position, got.count, got.last);
      end else begin
         want = pending_rsps.pop_front();
         if (want.status <= ST_NOTFOUND) status_seen[want.status]++;
         if (got.status !== want.status || got.item_value !== want.item_value ||
             got.item_position !== want.item_position || got.count !== want.count ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch at %0t: expected status=%0d value=%0d pos=%0d count=%0d last=%0d",
                        $realtime, want.status, want.item_value, want.item_position,
                        want.count, want.last);
               $display("                       got status=%0d value=%0d pos=%0d count=%0d last=%0d",
                        got.status, got.item_value, got.item_position, got.count, got.last);
            end
         end
      end
   endtask

   // watch both channels; retire responses, then predict the new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_rsp(rsp_payload);
         if (req_valid && !req_stall) begin
            list_apply(req_payload);
            if (offer_typed) pending_rsps.push_back(offer_exp);
            else foreach (step_rsps[k]) pending_rsps.push_back(step_rsps[k]);
            accepted_reqs++;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: shifting stall patterns and one long hold-off
   // ------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int          span;
      bit          held;
      mode = RX_FREE;
      span = 0;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (!held && accepted_reqs >= HOLD_AFTER) begin
            // hold off long enough for the block to back up its input
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               span = $urandom_range(20, 120);
            end
            span--;
            case (mode)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
               RX_BUSY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= (span % 3 == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------
   task automatic offer(input req_type r, input bit typed, input rsp_type e);
      req_valid   <= 1'b1;
      req_payload <= r;
      offer_typed <= typed;
      offer_exp   <= e;
      do @(posedge clock); while (req_stall);
   endtask

   // insert a gap between bursts of random length
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   // hold the sender until every outstanding response has arrived
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic script_row_type row(kind_type k, logic signed [31:0] v, logic [1:0] w,
                                          int p, int reps);
      script_row_type s;
      s.req.kind         = k;
      s.req.value        = v;
      s.req.insert_where = w;
      s.req.position     = p[7:0];
      s.reps             = reps;
      s.typed            = 1'b0;
      s.exp              = '0;
      return s;
   endfunction

   function automatic script_row_type typed_row(kind_type k, logic signed [31:0] v,
                                                logic [1:0] w, int p, status_type st,
                                                logic signed [31:0] ev, int epos, int ecnt);
      script_row_type s;
      s                   = row(k, v, w, p, 1);
      s.typed             = 1'b1;
      s.exp.status        = st;
      s.exp.item_value    = ev;
      s.exp.item_position = epos[3:0];
      s.exp.count         = ecnt[4:0];
      s.exp.last          = 1'b1;
      return s;
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
         4, 5:       return recent_vals.size() != 0 ?
                            recent_vals[$urandom_range(0, recent_vals.size() - 1)] : 0;
         6: begin
            case ($urandom_range(0, 3))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return -1;
               default: return 0;
            endcase
         end
         default:    return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick  = $urandom_range(0, 99);
      r.value = random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.insert_where = WHERE_POSITION;
         4, 5:       r.insert_where = WHERE_START;
         6, 7, 8:    r.insert_where = WHERE_END;
         default:    r.insert_where = WHERE_UNDEFINED;
      endcase
      r.position = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 17))
                                              : 8'($urandom_range(0, 255));
      if (pick < 50) begin
         r.kind = KIND_INSERT;
         recent_vals.push_back(r.value);
         if (recent_vals.size() > LIST_DEPTH) void'(recent_vals.pop_front());
      end else if (pick < 78) begin
         r.kind = KIND_DELETE;
         // mostly aim at values that are likely held
         if (recent_vals.size() != 0 && $urandom_range(0, 9) < 7)
            r.value = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      end else if (pick < 83) begin
         r.kind = KIND_CLEAR;
      end else begin
         r.kind = KIND_DUMP;
      end
      return r;
   endfunction

   initial begin
      script_row_type script [$];
      req_type        r;
      int             rep;
      int             n;

      // empty list, position errors, extremes, fill to full, middle and tail deletes
      script.push_back(typed_row(KIND_DUMP, 0, WHERE_END, 0, ST_EMPTY, 0, 0, 0));
      script.push_back(typed_row(KIND_DELETE, 5, WHERE_END, 0, ST_EMPTY, 0, 0, 0));
      script.push_back(typed_row(KIND_CLEAR, 0, WHERE_END, 0, ST_OK, 0, 0, 0));
      script.push_back(typed_row(KIND_INSERT, 9, WHERE_POSITION, 1, ST_BADPOS, 0, 0, 0));
      script.push_back(typed_row(KIND_INSERT, 9, WHERE_UNDEFINED, 0, ST_BADPOS, 0, 0, 0));
      script.push_back(typed_row(KIND_INSERT, VAL_MAX, WHERE_END, 0, ST_OK, VAL_MAX, 0, 1));
      script.push_back(typed_row(KIND_INSERT, VAL_MIN, WHERE_START, 200, ST_OK, VAL_MIN, 0, 2));
      script.push_back(row(KIND_INSERT, -1, WHERE_POSITION, 1, 1));
      script.push_back(typed_row(KIND_INSERT, 7, WHERE_POSITION, 255, ST_BADPOS, 0, 0, 3));
      script.push_back(typed_row(KIND_DELETE, 12345, WHERE_END, 0, ST_NOTFOUND, 0, 0, 3));
      script.push_back(row(KIND_INSERT, 100, WHERE_END, 0, 12));
      script.push_back(row(KIND_INSERT, 42, WHERE_POSITION, 15, 1));
      script.push_back(typed_row(KIND_INSERT, 1, WHERE_START, 0, ST_FULL, 0, 0, 16));
      script.push_back(row(KIND_DUMP, 0, WHERE_END, 0, 1));
      script.push_back(row(KIND_DELETE, -1, WHERE_END, 0, 1));
      script.push_back(row(KIND_DELETE, 42, WHERE_END, 0, 1));
      script.push_back(typed_row(KIND_CLEAR, 0, WHERE_END, 0, ST_OK, 0, 0, 0));
      script.push_back(typed_row(KIND_DUMP, 0, WHERE_END, 0, ST_EMPTY, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // walk the script; repeated rows step the value
      foreach (script[k]) begin
         for (rep = 0; rep < script[k].reps; rep++) begin
            r = script[k].req;
            r.value = r.value + rep;
            pace();
            offer(r, script[k].typed, script[k].exp);
            scripted_reqs++;
         end
      end

      for (n = 0; n < RANDOM_REQS; n++) begin
         if (n == RANDOM_REQS / 2) drain();
         pace();
         offer(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // let the tail of the work arrive, then look for strays
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests (%0d scripted) and checked %0d responses",
               accepted_reqs, scripted_reqs, checked_rsps);
      $display("mix: ok %0d, full %0d, bad position %0d, empty %0d, not found %0d; mismatches %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
               status_seen[ST_EMPTY], status_seen[ST_NOTFOUND], mismatches);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
